@@ rtl/core/rrep_pkg.sv @@
package rrep_pkg;

    localparam int MAX_ROW_PIXELS = 2048;
    localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
    localparam int LEN_W          = COL_W + 1;
    localparam int QW             = COL_W - 1;
    localparam int MEM_AW         = QW + 1;
    localparam int DIV_SHIFT      = COL_W + 1;
    localparam int DIV_MULT       = (2 ** DIV_SHIFT + 2) / 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_PIXELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GREYSCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd6;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [7:0] CHANNEL_MAX     = 8'd255;
    localparam logic [7:0] THRESHOLD_LEVEL = 8'd127;

    typedef struct packed {
        logic       cmd;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_word;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end;
    } t_out_word;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] row_pixels;
        logic                  greyscale_on;
        logic                  mirror_on;
        logic [2:0]            invert_mask;
        logic [2:0]            zero_mask;
        logic                  blur_on;
        logic                  threshold_on;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic       full;
        logic [1:0] sel;
        logic       last;
    } t_rd_tag;

    typedef struct packed {
        logic                       wr_en;
        logic [1:0]                 wr_way;
        logic [MEM_AW-1:0]          wr_addr;
        logic [23:0]                wr_data;
        logic [2:0][MEM_AW-1:0]     rd_addr;
    } t_mem_req;

    function automatic logic [7:0] div3_sum(input logic [9:0] s);
        logic [19:0] prod;
        prod = {10'd0, s} * 20'd683;
        return prod[18:11];
    endfunction

    function automatic logic [QW-1:0] div3_col(input logic [COL_W-1:0] c);
        logic [COL_W+DIV_SHIFT-1:0] prod;
        prod = {{DIV_SHIFT{1'b0}}, c} * (COL_W + DIV_SHIFT)'(DIV_MULT);
        return prod[DIV_SHIFT +: QW];
    endfunction

    function automatic logic [LEN_W-1:0] row_len(input logic [CFG_DATA_W-1:0] v);
        logic [LEN_W-1:0] res;
        if (v == '0) begin
            res = LEN_W'(1);
        end else if ({1'b0, v} > (CFG_DATA_W + 1)'(MAX_ROW_PIXELS)) begin
            res = LEN_W'(MAX_ROW_PIXELS);
        end else begin
            res = LEN_W'(v);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/rrep_line_store.sv @@
module rrep_line_store
    import rrep_pkg::*;
(
    input  logic                i_clk,
    input  t_mem_req            i_req,
    output logic [2:0][23:0]    o_rdata
);

    logic [23:0] r_mem [3][2 ** MEM_AW];
    logic [2:0][23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 3; b++) begin
            if (i_req.wr_en && (i_req.wr_way == 2'(b))) begin
                r_mem[b][i_req.wr_addr] <= i_req.wr_data;
            end
            r_rdata[b] <= r_mem[b][i_req.rd_addr[b]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rrep_ctrl.sv @@
module rrep_ctrl
    import rrep_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_word i_word,
    output t_mem_req o_req,
    output t_rd_tag  o_tag
);

    logic             r_pending, n_pending;
    logic             r_bank, n_bank;
    logic [COL_W-1:0] r_wcol, n_wcol;
    logic [QW-1:0]    r_wq, n_wq;
    logic [1:0]       r_wr, n_wr;
    logic [COL_W-1:0] r_rpos, n_rpos;
    logic [1:0]       r_rr, n_rr;
    t_rd_tag          r_tag;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] p_ext;
    logic [COL_W-1:0] gs;
    logic             have;
    logic             full;
    logic [LEN_W-1:0] c0_ext;
    logic [COL_W-1:0] c0;
    logic [QW-1:0]    q0;
    logic [COL_W-1:0] q3;
    logic [1:0]       r0;
    logic             wr_pixel;

    assign len   = row_len(i_cfg.row_pixels);
    assign p_ext = {1'b0, r_rpos};
    assign gs    = r_rpos - COL_W'(r_rr);
    assign have  = r_pending && (p_ext < len);
    assign full  = i_cfg.blur_on && (({1'b0, gs} + LEN_W'(2)) < len);

    always_comb begin
        if (full) begin
            c0_ext = i_cfg.mirror_on ? (len - LEN_W'(3) - {1'b0, gs}) : {1'b0, gs};
        end else begin
            c0_ext = i_cfg.mirror_on ? (len - LEN_W'(1) - p_ext) : p_ext;
        end
    end

    assign c0 = c0_ext[COL_W-1:0];
    assign q0 = div3_col(c0);
    assign q3 = {q0, 1'b0} + {1'b0, q0};
    assign r0 = 2'(c0 - q3);

    assign wr_pixel = i_accept && (i_word.cmd == CMD_PIXEL);

    always_comb begin
        o_req.wr_en   = wr_pixel;
        o_req.wr_way  = r_wr;
        o_req.wr_addr = {r_bank, r_wq};
        o_req.wr_data = {i_word.blue_in, i_word.green_in, i_word.red_in};
        for (int b = 0; b < 3; b++) begin
            o_req.rd_addr[b] = {~r_bank, q0 + QW'((2'(b) < r0) ? 1 : 0)};
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_bank    = r_bank;
        n_wcol    = r_wcol;
        n_wq      = r_wq;
        n_wr      = r_wr;
        n_rpos    = r_rpos;
        n_rr      = r_rr;
        if (i_accept && r_pending) begin
            if (!have || ((p_ext + LEN_W'(1)) >= len)) begin
                n_pending = 1'b0;
                n_rpos    = '0;
                n_rr      = '0;
            end else begin
                n_rpos = r_rpos + COL_W'(1);
                if (r_rr == 2'd2) begin
                    n_rr = '0;
                end else begin
                    n_rr = r_rr + 2'd1;
                end
            end
        end
        if (wr_pixel) begin
            if (({1'b0, r_wcol} + LEN_W'(1)) >= len) begin
                n_pending = 1'b1;
                n_rpos    = '0;
                n_rr      = '0;
                n_bank    = ~r_bank;
                n_wcol    = '0;
                n_wq      = '0;
                n_wr      = '0;
            end else begin
                n_wcol = r_wcol + COL_W'(1);
                if (r_wr == 2'd2) begin
                    n_wr = '0;
                    n_wq = r_wq + QW'(1);
                end else begin
                    n_wr = r_wr + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_bank      <= 1'b0;
            r_wcol      <= '0;
            r_wq        <= '0;
            r_wr        <= '0;
            r_rpos      <= '0;
            r_rr        <= '0;
            r_tag.valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_bank      <= n_bank;
            r_wcol      <= n_wcol;
            r_wq        <= n_wq;
            r_wr        <= n_wr;
            r_rpos      <= n_rpos;
            r_rr        <= n_rr;
            r_tag.valid <= i_accept && have;
        end
        r_tag.full <= full;
        r_tag.sel  <= r0;
        r_tag.last <= (p_ext == (len - LEN_W'(1)));
    end

    assign o_tag = r_tag;

endmodule

@@ rtl/core/rrep_fx.sv @@
module rrep_fx
    import rrep_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_rd_tag          i_tag,
    input  logic [2:0][23:0] i_rdata,
    output logic [1:0]       o_busy,
    output logic             o_valid,
    output t_out_word        o_word
);

    logic             r_a_valid;
    logic             r_a_full;
    logic [1:0]       r_a_sel;
    logic             r_a_last;
    logic [2:0][23:0] r_a_pix;
    logic [2:0][23:0] n_a_pix;

    logic             r_b_valid;
    t_out_word        r_b_word;
    logic [23:0]      n_b_pix;

    always_comb begin
        logic [7:0] ch [3];
        logic [7:0] grey;
        for (int w = 0; w < 3; w++) begin
            ch[0] = i_rdata[w][7:0];
            ch[1] = i_rdata[w][15:8];
            ch[2] = i_rdata[w][23:16];
            grey  = div3_sum({2'b00, ch[0]} + {2'b00, ch[1]} + {2'b00, ch[2]});
            for (int i = 0; i < 3; i++) begin
                if (i_cfg.greyscale_on) begin
                    ch[i] = grey;
                end
                if (i_cfg.invert_mask[i]) begin
                    ch[i] = CHANNEL_MAX - ch[i];
                end
                if (i_cfg.zero_mask[i]) begin
                    ch[i] = '0;
                end
            end
            n_a_pix[w] = {ch[2], ch[1], ch[0]};
        end
    end

    always_comb begin
        logic [7:0] v;
        n_b_pix = r_a_pix[r_a_sel];
        for (int i = 0; i < 3; i++) begin
            if (r_a_full) begin
                v = div3_sum({2'b00, r_a_pix[0][8*i +: 8]} + {2'b00, r_a_pix[1][8*i +: 8]}
                             + {2'b00, r_a_pix[2][8*i +: 8]});
            end else begin
                v = n_b_pix[8*i +: 8];
            end
            if (i_cfg.threshold_on) begin
                v = (v >= THRESHOLD_LEVEL) ? CHANNEL_MAX : 8'd0;
            end
            n_b_pix[8*i +: 8] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_tag.valid;
            r_b_valid <= r_a_valid;
        end
        r_a_full           <= i_tag.full;
        r_a_sel            <= i_tag.sel;
        r_a_last           <= i_tag.last;
        r_a_pix            <= n_a_pix;
        r_b_word.red_out   <= n_b_pix[7:0];
        r_b_word.green_out <= n_b_pix[15:8];
        r_b_word.blue_out  <= n_b_pix[23:16];
        r_b_word.row_end   <= r_a_last;
    end

    assign o_busy  = {1'b0, r_a_valid} + {1'b0, r_b_valid};
    assign o_valid = r_b_valid;
    assign o_word  = r_b_word;

endmodule

@@ rtl/core/rgb_row_effects_pipeline.sv @@
// RGB row effects pipeline.
// Input channel (i_in_valid / o_in_stall / i_in_word): cmd 0 stores a pixel
// into the row bank being filled, cmd 1 is a flush. Every input word, pixel or
// flush, also emits the next pixel of the last completed row, if one is pending.
// Output channel (o_out_valid / i_out_stall / o_out_word): processed pixels in
// row order (reversed when mirroring), row_end set on the last one of a row.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data, register index 0 row_pixels,
// 1 greyscale, 2 mirror, 3 invert mask, 4 zero mask, 5 blur, 6 threshold.
// Write registers only while the block is idle.
// Throughput: one input word per cycle while o_in_stall is low. The line store
// is three simple dual-port RAMs interleaved by column modulo 3, so a full blur
// group is fetched in one read. A result goes to the output after its input word
// is accepted through the RAM read on the accepting edge, then per-pixel effects,
// blur and threshold, and the queue write, each registered.
// The output side has an 8-word queue; o_in_stall rises only when the queue plus
// words in flight could overflow, so a stalled receiver backs up the input and
// no word is lost. o_in_stall comes from registers only.
// Reset clears the row state and the queue and loads the register defaults; line
// store contents stay undefined until written.
module rgb_row_effects_pipeline
    import rrep_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    t_cfg             r_cfg;
    t_mem_req         mem_req;
    t_rd_tag          tag;
    logic [2:0][23:0] rdata;
    logic [1:0]       fx_busy;
    logic             fx_valid;
    t_out_word        fx_word;
    logic             accept;

    t_out_word          r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_head;
    logic [FIFO_AW-1:0] r_tail;
    logic [FIFO_AW:0]   r_cnt;
    logic               pop;
    logic [FIFO_AW+1:0] occupancy;

    assign occupancy  = {1'b0, r_cnt} + (FIFO_AW + 2)'(tag.valid) + (FIFO_AW + 2)'(fx_busy);
    assign o_in_stall = occupancy >= (FIFO_AW + 2)'(FIFO_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_pixels   <= CFG_DATA_W'(1);
            r_cfg.greyscale_on <= 1'b0;
            r_cfg.mirror_on    <= 1'b0;
            r_cfg.invert_mask  <= '0;
            r_cfg.zero_mask    <= '0;
            r_cfg.blur_on      <= 1'b0;
            r_cfg.threshold_on <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_PIXELS:  r_cfg.row_pixels   <= i_cfg_data;
                REG_GREYSCALE:   r_cfg.greyscale_on <= i_cfg_data[0];
                REG_MIRROR:      r_cfg.mirror_on    <= i_cfg_data[0];
                REG_INVERT_MASK: r_cfg.invert_mask  <= i_cfg_data[2:0];
                REG_ZERO_MASK:   r_cfg.zero_mask    <= i_cfg_data[2:0];
                REG_BLUR:        r_cfg.blur_on      <= i_cfg_data[0];
                REG_THRESHOLD:   r_cfg.threshold_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rrep_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_word   (i_in_word),
        .o_req    (mem_req),
        .o_tag    (tag)
    );

    rrep_line_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    rrep_fx u_fx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_tag   (tag),
        .i_rdata (rdata),
        .o_busy  (fx_busy),
        .o_valid (fx_valid),
        .o_word  (fx_word)
    );

    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_word  = r_fifo[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (fx_valid) begin
                r_tail <= r_tail + FIFO_AW'(1);
            end
            if (pop) begin
                r_head <= r_head + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (FIFO_AW + 1)'(fx_valid) - (FIFO_AW + 1)'(pop);
        end
        if (fx_valid) begin
            r_fifo[r_tail] <= fx_word;
        end
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rrep_pkg::*;

    localparam int unsigned TOTAL_WORDS  = 1550;
    localparam int unsigned BIG_PHASE    = 4;
    localparam int unsigned BIG_ROW      = 300;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS  = 100;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{
        REG_ROW_PIXELS, REG_GREYSCALE, REG_MIRROR, REG_INVERT_MASK,
        REG_ZERO_MASK, REG_BLUR, REG_THRESHOLD
    };

    class row_effects_scoreboard;
        logic [2:0][7:0] line_px [2*MAX_ROW_PIXELS];
        t_cfg            regs;
        int unsigned     wr_col;
        int unsigned     rd_pos;
        bit              row_ready;
        bit              wr_bank;
        t_out_word       pixels_due [$];
        int unsigned     errors;

        function new();
            regs            = '0;
            regs.row_pixels = CFG_DATA_W'(1);
            wr_col          = 0;
            rd_pos          = 0;
            row_ready       = 1'b0;
            wr_bank         = 1'b0;
            errors          = 0;
        endfunction

        function int unsigned row_length(logic [CFG_DATA_W-1:0] v);
            int unsigned n;
            n = v;
            if (n == 0) n = 1;
            if (n > MAX_ROW_PIXELS) n = MAX_ROW_PIXELS;
            return n;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROW_PIXELS:  regs.row_pixels   = data;
                REG_GREYSCALE:   regs.greyscale_on = data[0];
                REG_MIRROR:      regs.mirror_on    = data[0];
                REG_INVERT_MASK: regs.invert_mask  = data[2:0];
                REG_ZERO_MASK:   regs.zero_mask    = data[2:0];
                REG_BLUR:        regs.blur_on      = data[0];
                REG_THRESHOLD:   regs.threshold_on = data[0];
                default: ;
            endcase
        endfunction

        // pixel at output position p of the completed row, before blur and threshold
        function logic [2:0][7:0] shade(int unsigned p, int unsigned n);
            logic [2:0][7:0] px;
            int unsigned     col;
            int unsigned     grey;
            col = regs.mirror_on ? n - 1 - p : p;
            px  = line_px[(wr_bank ? 0 : MAX_ROW_PIXELS) + col];
            if (regs.greyscale_on) begin
                grey = (int'(px[0]) + int'(px[1]) + int'(px[2])) / 3;
                px   = {3{8'(grey)}};
            end
            for (int i = 0; i < 3; i++) begin
                if (regs.invert_mask[i]) px[i] = CHANNEL_MAX - px[i];
                if (regs.zero_mask[i]) px[i] = 8'd0;
            end
            return px;
        endfunction

        function void emit_pixel();
            int unsigned     n;
            int unsigned     p;
            int unsigned     base;
            logic [2:0][7:0] a;
            logic [2:0][7:0] b;
            logic [2:0][7:0] c;
            logic [2:0][7:0] px;
            t_out_word       res;
            n = row_length(regs.row_pixels);
            p = rd_pos;
            if (p >= n) begin
                row_ready = 1'b0;
                rd_pos    = 0;
                return;
            end
            base = p - p % 3;
            if (regs.blur_on && base + 2 < n) begin
                a = shade(base, n);
                b = shade(base + 1, n);
                c = shade(base + 2, n);
                for (int i = 0; i < 3; i++) begin
                    px[i] = 8'((int'(a[i]) + int'(b[i]) + int'(c[i])) / 3);
                end
            end else begin
                px = shade(p, n);
            end
            if (regs.threshold_on) begin
                for (int i = 0; i < 3; i++) begin
                    px[i] = (px[i] >= THRESHOLD_LEVEL) ? CHANNEL_MAX : 8'd0;
                end
            end
            res.red_out   = px[0];
            res.green_out = px[1];
            res.blue_out  = px[2];
            res.row_end   = (p == n - 1);
            pixels_due.push_back(res);
            rd_pos = p + 1;
            if (rd_pos >= n) begin
                row_ready = 1'b0;
                rd_pos    = 0;
            end
        endfunction

        function void note_word(t_in_word w);
            int unsigned n;
            int unsigned col;
            n = row_length(regs.row_pixels);
            if (row_ready) emit_pixel();
            if (w.cmd == CMD_FLUSH) return;
            col = wr_col % MAX_ROW_PIXELS;
            line_px[(wr_bank ? MAX_ROW_PIXELS : 0) + col] = {w.blue_in, w.green_in, w.red_in};
            if (col + 1 >= n) begin
                row_ready = 1'b1;
                rd_pos    = 0;
                wr_bank   = !wr_bank;
                wr_col    = 0;
            end else begin
                wr_col = col + 1;
            end
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
                end
                errors++;
            end
        endfunction

        function void check_pixel(t_out_word got);
            t_out_word want;
            if (pixels_due.size() == 0) begin
                if (errors < MAX_REPORTS) begin
                    $display("%0t: pixel expected none got %h", $time, got);
                end
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            compare("red_out", want.red_out, got.red_out);
            compare("green_out", want.green_out, got.green_out);
            compare("blue_out", want.blue_out, got.blue_out);
            compare("row_end", 8'(want.row_end), 8'(got.row_end));
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    row_effects_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pct  = 0;
    int unsigned idle_count = 0;
    int unsigned sent_words = 0;

    rgb_row_effects_pipeline dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(8, 200);
            case ($urandom_range(0, 4))
                0, 1:    stall_pct <= 0;
                2:       stall_pct <= 20;
                3:       stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_pixel(out_word);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= IDLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return CHANNEL_MAX;
            2:       return THRESHOLD_LEVEL - 8'd1 + 8'($urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_word pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_in_word w;
        w.cmd      = CMD_PIXEL;
        w.red_in   = r;
        w.green_in = g;
        w.blue_in  = b;
        return w;
    endfunction

    function automatic t_in_word random_word(int unsigned flush_pct);
        t_in_word w;
        w     = pixel(rand_level(), rand_level(), rand_level());
        w.cmd = ($urandom_range(0, 99) < flush_pct) ? CMD_FLUSH : CMD_PIXEL;
        return w;
    endfunction

    function automatic t_in_word flush_word();
        return random_word(100);
    endfunction

    function automatic t_cfg make_cfg(logic [CFG_DATA_W-1:0] rows, logic grey, logic mir,
                                      logic [2:0] inv, logic [2:0] zero, logic blur,
                                      logic thr);
        t_cfg c;
        c.row_pixels   = rows;
        c.greyscale_on = grey;
        c.mirror_on    = mir;
        c.invert_mask  = inv;
        c.zero_mask    = zero;
        c.blur_on      = blur;
        c.threshold_on = thr;
        return c;
    endfunction

    function automatic t_cfg random_cfg();
        int unsigned rows;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) rows = 0;
        else if (pick < 15) rows = 1;
        else if (pick < 25) rows = $urandom_range(2, 3);
        else if (pick < 85) rows = $urandom_range(4, 24);
        else rows = $urandom_range(25, 200);
        return make_cfg(CFG_DATA_W'(rows), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        3'($urandom_range(0, 7)),
                        ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 7)),
                        1'($urandom_range(0, 1)), ($urandom_range(0, 2) == 0));
    endfunction

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        sb.note_word(w);
        sent_words++;
    endtask

    // hold input until every pending pixel is out, then let in-flight words retire
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        logic [CFG_DATA_W-1:0] vals [7];
        vals[0] = c.row_pixels;
        vals[1] = CFG_DATA_W'(c.greyscale_on);
        vals[2] = CFG_DATA_W'(c.mirror_on);
        vals[3] = CFG_DATA_W'(c.invert_mask);
        vals[4] = CFG_DATA_W'(c.zero_mask);
        vals[5] = CFG_DATA_W'(c.blur_on);
        vals[6] = CFG_DATA_W'(c.threshold_on);
        for (int i = 0; i < 7; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= REG_ORDER[i];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.write_reg(REG_ORDER[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic drain_row();
        while (sb.row_ready) send_word(flush_word());
    endtask

    initial begin
        t_cfg        c;
        t_in_word    w;
        int unsigned phase;
        int unsigned phase_words;
        int unsigned flush_pct;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default length of one pixel: flush on empty, first row, back-to-back rows
        send_word(flush_word());
        send_word(pixel(8'd255, 8'd0, 8'd127));
        send_word(pixel(8'd0, 8'd255, 8'd128));
        send_word(flush_word());
        send_word(flush_word());
        settle();

        // zero length, full invert and threshold edge
        apply_cfg(make_cfg('0, 1'b0, 1'b0, 3'b111, 3'b000, 1'b0, 1'b1));
        send_word(pixel(8'd126, 8'd127, 8'd128));
        send_word(flush_word());
        settle();

        // greyscale, mirror, blur with a partial last group
        apply_cfg(make_cfg(CFG_DATA_W'(5), 1'b1, 1'b1, 3'b000, 3'b010, 1'b1, 1'b0));
        send_word(pixel(8'd255, 8'd255, 8'd255));
        send_word(pixel(8'd0, 8'd0, 8'd0));
        send_word(pixel(8'd1, 8'd2, 8'd3));
        send_word(pixel(8'd127, 8'd128, 8'd126));
        send_word(pixel(8'd200, 8'd10, 8'd90));
        repeat (5) send_word(flush_word());
        settle();

        // shrink the row while one is pending and another is half written
        apply_cfg(make_cfg(CFG_DATA_W'(4), 1'b0, 1'b0, 3'b000, 3'b000, 1'b0, 1'b0));
        repeat (6) send_word(random_word(0));
        settle();
        apply_cfg(make_cfg(CFG_DATA_W'(2), 1'b0, 1'b0, 3'b101, 3'b000, 1'b0, 1'b0));
        send_word(random_word(0));
        send_word(flush_word());
        send_word(flush_word());

        phase = 0;
        while (sent_words < TOTAL_WORDS) begin
            settle();
            if (phase == BIG_PHASE) begin
                c = make_cfg(CFG_DATA_W'(BIG_ROW), 1'($urandom_range(0, 1)), 1'b1,
                             3'($urandom_range(0, 7)), 3'b000, 1'b1, 1'b0);
            end else begin
                c = random_cfg();
            end
            if (sb.row_ready &&
                sb.row_length(c.row_pixels) > sb.row_length(sb.regs.row_pixels)) begin
                drain_row();
                settle();
            end
            apply_cfg(c);
            if (phase == BIG_PHASE) begin
                phase_words = 2 * BIG_ROW + 5;
                flush_pct   = 0;
            end else begin
                phase_words = $urandom_range(10, 120);
                flush_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
            end
            repeat (phase_words) begin
                w = random_word(flush_pct);
                send_word(w);
            end
            phase++;
        end

        settle();
        if (sb.errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
